FILE: design/wfg_pkg.sv
// Shared constants, codes and command/status types for the wait-for-graph grant check.
`timescale 1ns / 1ps
`default_nettype none
package wfg_pkg;

  localparam int MAX_PROCS   = 8;
  localparam int MAX_CLASSES = 8;
  localparam int UNIT_BITS   = 8;

  localparam int PROC_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CLS_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int NP_W    = $clog2(MAX_PROCS + 1);
  localparam int NC_W    = $clog2(MAX_CLASSES + 1);
  localparam int ADDR_W  = PROC_W + CLS_W;
  localparam int ENTRIES = 2 ** ADDR_W;
  localparam int STEPS   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CL_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [1:0] FN_FREE  = 2'd0;
  localparam logic [1:0] FN_HELD  = 2'd1;
  localparam logic [1:0] FN_OUT   = 2'd2;
  localparam logic [1:0] FN_CHECK = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_CYCLE = 2'd2,
    ST_RANGE = 2'd3
  } stat_e;

  typedef struct packed {
    logic load;
    logic eval_fin;
    logic sweep;
    logic close;
    logic check_fin;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic is_check;
    logic short_units;
    logic sweep_last;
    logic close_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/wfg_ctrl.sv
// Sequencer for the grant check: load, evaluate, sweep tables, close graph, report.
`timescale 1ns / 1ps
`default_nettype none
module wfg_ctrl import wfg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.bad || !sts_i.is_check || sts_i.short_units) begin
          if (sts_i.out_free) begin
            cmd_o.eval_fin = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_CLOSE;
      S_CLOSE: begin
        cmd_o.close = 1'b1;
        if (sts_i.close_last) state_d = S_FINAL;
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.check_fin = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.eval_fin || cmd_o.check_fin) |-> sts_i.out_free)
    else $error("result committed while output register busy");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.eval_fin, cmd_o.sweep, cmd_o.close, cmd_o.check_fin}))
    else $error("more than one command at once");
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sweep && sts_i.sweep_last) |=> !cmd_o.sweep)
    else $error("sweep ran past its last entry");

endmodule
`default_nettype wire

FILE: design/wfg_dp.sv
// Datapath: item registers, unit tables, wait-for graph build and closure, result register.
`timescale 1ns / 1ps
`default_nettype none
module wfg_dp import wfg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [NP_W-1:0]   np_i,
  input  wire logic [NC_W-1:0]   nc_i,
  input  wire logic [1:0]        func_i,
  input  wire logic [2:0]        proc_index_i,
  input  wire logic [2:0]        class_index_i,
  input  wire logic [7:0]        amount_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   granted_o,
  output logic [1:0]             status_o,
  output logic [31:0]            refusal_count_o
);

  // item
  logic [1:0] func_q;
  logic [2:0] pid_q, rc_q;
  logic [7:0] amt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      pid_q  <= proc_index_i;
      rc_q   <= class_index_i;
      amt_q  <= amount_i;
    end
  end

  logic [PROC_W-1:0] pid;
  logic [CLS_W-1:0]  rc;
  assign pid = pid_q[PROC_W-1:0];
  assign rc  = rc_q[CLS_W-1:0];

  logic bad;
  assign bad = (rc_q >= nc_i) || ((func_q != FN_FREE) && (pid_q >= np_i));

  // free units
  logic [UNIT_BITS-1:0] free_q [MAX_CLASSES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) free_q[i] <= '0;
    end else if (cmd_i.eval_fin && !bad && func_q == FN_FREE) begin
      free_q[rc] <= UNIT_BITS'(amt_q);
    end
  end

  // held / outstanding memories with per-entry valid bits
  logic [UNIT_BITS-1:0] held_mem [ENTRIES];
  logic [UNIT_BITS-1:0] out_mem  [ENTRIES];
  logic [ENTRIES-1:0]   held_vld_q, out_vld_q;
  logic [UNIT_BITS-1:0] held_rd_q, out_rd_q;
  logic                 held_ok_q, out_ok_q;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic                 wr_held, wr_out;
  logic [PROC_W-1:0]    sw_p_q;
  logic [CLS_W-1:0]     sw_r_q;

  assign wr_addr = {pid, rc};
  assign rd_addr = {sw_p_q, sw_r_q};
  assign wr_held = cmd_i.eval_fin && !bad && func_q == FN_HELD;
  assign wr_out  = cmd_i.eval_fin && !bad && func_q == FN_OUT;

  always_ff @(posedge clk_i) begin
    if (wr_held) held_mem[wr_addr] <= UNIT_BITS'(amt_q);
    if (wr_out)  out_mem[wr_addr]  <= UNIT_BITS'(amt_q);
    held_rd_q <= held_mem[rd_addr];
    out_rd_q  <= out_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= '0;
      out_vld_q  <= '0;
      held_ok_q  <= 1'b0;
      out_ok_q   <= 1'b0;
    end else begin
      if (wr_held) held_vld_q[wr_addr] <= 1'b1;
      if (wr_out)  out_vld_q[wr_addr]  <= 1'b1;
      held_ok_q <= held_vld_q[rd_addr];
      out_ok_q  <= out_vld_q[rd_addr];
    end
  end

  // sweep counters, p inner, r outer
  logic p_end, r_end;
  assign p_end = ({1'b0, sw_p_q} == (PROC_W + 1)'(np_i - 1'b1));
  assign r_end = ({1'b0, sw_r_q} == (CLS_W + 1)'(nc_i - 1'b1));

  logic              m_v_q, m_cend_q;
  logic [PROC_W-1:0] m_p_q;
  logic [CLS_W-1:0]  m_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_p_q <= '0;
      sw_r_q <= '0;
      m_v_q  <= 1'b0;
    end else begin
      m_v_q <= cmd_i.sweep;
      if (cmd_i.load) begin
        sw_p_q <= '0;
        sw_r_q <= '0;
      end else if (cmd_i.sweep) begin
        if (p_end) begin
          sw_p_q <= '0;
          sw_r_q <= sw_r_q + 1'b1;
        end else begin
          sw_p_q <= sw_p_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_p_q    <= sw_p_q;
    m_r_q    <= sw_r_q;
    m_cend_q <= p_end;
  end

  // graph build and closure
  logic [UNIT_BITS-1:0] held_v, out_v;
  logic                 hit, w_bit, h_bit;
  logic [MAX_PROCS-1:0] w_q, h_q, w_new, h_new;
  logic [MAX_PROCS-1:0] g_q [MAX_PROCS];
  logic [MAX_PROCS-1:0] g_d [MAX_PROCS];
  logic [CL_W-1:0]      cl_q;
  logic                 cyc;

  assign held_v = held_ok_q ? held_rd_q : '0;
  assign out_v  = out_ok_q ? out_rd_q : '0;
  assign hit    = (m_p_q == pid) && (m_r_q == rc);
  assign w_bit  = hit ? (out_v > amt_q) : (out_v != '0);
  assign h_bit  = (held_v != '0) || (hit && amt_q != '0);
  assign w_new  = w_q | (MAX_PROCS'(w_bit) << m_p_q);
  assign h_new  = h_q | (MAX_PROCS'(h_bit) << m_p_q);

  always_comb begin
    for (int a = 0; a < MAX_PROCS; a++) begin
      g_d[a] = g_q[a];
      if (cmd_i.close) begin
        for (int k = 0; k < MAX_PROCS; k++) begin
          if (g_q[a][k]) g_d[a] = g_d[a] | g_q[k];
        end
      end else if (m_v_q && m_cend_q && w_new[a]) begin
        g_d[a] = g_q[a] | (h_new & ~(MAX_PROCS'(1) << a));
      end
    end
  end

  always_comb begin
    cyc = 1'b0;
    for (int a = 0; a < MAX_PROCS; a++) cyc = cyc | g_q[a][a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= '0;
      h_q  <= '0;
      cl_q <= '0;
      for (int a = 0; a < MAX_PROCS; a++) g_q[a] <= '0;
    end else if (cmd_i.load) begin
      w_q  <= '0;
      h_q  <= '0;
      cl_q <= '0;
      for (int a = 0; a < MAX_PROCS; a++) g_q[a] <= '0;
    end else begin
      if (m_v_q) begin
        w_q <= m_cend_q ? '0 : w_new;
        h_q <= m_cend_q ? '0 : h_new;
      end
      if (cmd_i.close) cl_q <= cl_q + 1'b1;
      for (int a = 0; a < MAX_PROCS; a++) g_q[a] <= g_d[a];
    end
  end

  // result register and refusal counter
  logic        out_valid_q, granted_q, refuse;
  stat_e       status_q;
  logic [31:0] refusals_q, ref_next;
  logic        fin;

  assign fin      = cmd_i.eval_fin || cmd_i.check_fin;
  assign refuse   = (cmd_i.eval_fin && !bad && func_q == FN_CHECK)
                  || (cmd_i.check_fin && cyc);
  assign ref_next = (refuse && refusals_q != '1) ? refusals_q + 32'd1 : refusals_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      refusals_q  <= '0;
    end else begin
      refusals_q <= ref_next;
      if (fin)               out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_fin) begin
      priority if (bad) begin
        granted_q <= 1'b0;
        status_q  <= ST_RANGE;
      end else if (func_q != FN_CHECK) begin
        granted_q <= 1'b1;
        status_q  <= ST_OK;
      end else begin
        granted_q <= 1'b0;
        status_q  <= ST_SHORT;
      end
    end else if (cmd_i.check_fin) begin
      granted_q <= !cyc;
      status_q  <= cyc ? ST_CYCLE : ST_OK;
    end
    if (fin) refusal_count_o <= ref_next;
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign status_o    = status_q;

  assign sts_o.bad         = bad;
  assign sts_o.is_check    = (func_q == FN_CHECK);
  assign sts_o.short_units = (amt_q > free_q[rc]);
  assign sts_o.sweep_last  = p_end && r_end;
  assign sts_o.close_last  = (cl_q == CL_W'(STEPS - 1));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

FILE: design/wait_for_graph_grant_check.sv
// Top level of the wait-for-graph grant check: configuration port, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps free units per resource class and held/outstanding units per
// process and class. Items with func 0..2 load those tables; func 3 asks whether a
// process may take amount units of a class. A check with enough free units builds a
// wait-for graph on the trial state (process A waits on B when some class has A
// still outstanding and B holding) and refuses the grant if the graph has a cycle.
// One item is in work at a time; a new item is taken while the previous result still
// sits in the output register. Writes, out-of-range items and short-of-units checks
// reach the output register from the evaluate state, and the next item is then taken
// in the idle state. A full check reaches the output register from the final state:
// the held and outstanding tables are memories swept one entry per cycle over a single
// read port, followed by a drain state and log2(8) = 3 squaring steps of the
// reachability matrix. A result that finds the output register still held by a stalled
// result waits there until the stall clears. The tables read as zero until written
// (per-entry valid bits), so no clearing pass follows reset. procs_in_use (address 0)
// and classes_in_use (address 4) reset to 8 and are clamped to 8; write them only
// while the block is idle.
module wait_for_graph_grant_check import wfg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  proc_index_i,
  input  wire logic [2:0]  class_index_i,
  input  wire logic [7:0]  amount_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             granted_o,
  output logic [1:0]       status_o,
  output logic [31:0]      refusal_count_o
);

  logic [3:0]      procs_q, classes_q;
  logic [NP_W-1:0] np_eff;
  logic [NC_W-1:0] nc_eff;
  cmd_t            cmd;
  sts_t            sts;

  // Registers decode on the word address; byte offset bits are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q   <= 4'd8;
      classes_q <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) classes_q <= pwdata[3:0];
      else          procs_q   <= pwdata[3:0];
    end
  end

  assign prdata = paddr[2] ? {28'd0, classes_q} : {28'd0, procs_q};

  // Clamp the register values to the table sizes.
  assign np_eff = (32'(procs_q) > MAX_PROCS) ? NP_W'(MAX_PROCS) : NP_W'(procs_q);
  assign nc_eff = (32'(classes_q) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(classes_q);

  wfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wfg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .np_i            (np_eff),
    .nc_i            (nc_eff),
    .func_i          (func_i),
    .proc_index_i    (proc_index_i),
    .class_index_i   (class_index_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_o       (granted_o),
    .status_o        (status_o),
    .refusal_count_o (refusal_count_o)
  );

endmodule
`default_nettype wire
